### rtl/lfsf_pkg.sv
// ----------------------------------------------------------------------------
// lfsf_pkg
// Shared types, codes and the byte-to-level map of the LED frame source.
// ----------------------------------------------------------------------------
package lfsf_pkg;

	localparam int BYTE_W    = 8;
	localparam int LEVEL_W   = 4;
	localparam int CH_W      = 3;
	localparam int MODE_W    = 2;
	localparam int KIND_W    = 3;
	localparam int COUNT_W   = 4;
	localparam int FRAME_W   = 64;
	localparam int TMO_W     = 16;
	localparam int SINCE_W   = 32;
	localparam int S_DATA_W  = 72;
	localparam int M_DATA_W  = 16;
	localparam int APB_ADDR_W = 3;
	localparam int APB_DATA_W = 32;
	localparam int LEVEL_MAX = 9;
	localparam int BYTE_MAX  = 255;
	localparam logic [TMO_W-1:0] TMO_RESET = 16'd5000;

	typedef enum logic [KIND_W-1:0] {
		KIND_STATIC  = 3'd0,
		KIND_PLANNED = 3'd1,
		KIND_FAST    = 3'd2,
		KIND_TICK    = 3'd3,
		KIND_FORCE   = 3'd4
	} kind_t;

	typedef enum logic [MODE_W-1:0] {
		SRC_STATIC  = 2'd0,
		SRC_PLANNED = 2'd1,
		SRC_FAST    = 2'd2
	} mode_t;

	localparam logic [0:0] REG_FAST_TIMEOUT = 1'b0;

	typedef struct packed {
		logic                changed;
		logic [LEVEL_W-1:0]  level;
	} lane_res_t;

	function automatic logic [LEVEL_W-1:0] level_of(input logic [BYTE_W-1:0] b);
		logic [11:0]        prod;
		logic [LEVEL_W-1:0] lvl;
		prod = 12'(b) * 12'(LEVEL_MAX);
		lvl = '0;
		for (int k = 1; k <= LEVEL_MAX; k++) begin
			if (prod >= 12'(k * BYTE_MAX)) begin
				lvl = lvl + 4'd1;
			end
		end
		return lvl;
	endfunction

endpackage

### rtl/lfsf_lane.sv
// ----------------------------------------------------------------------------
// lfsf_lane
// One channel lane: maps the shown byte to a level, compares it with the
// level in use and holds the new level once the frame is taken.
// ----------------------------------------------------------------------------
module lfsf_lane (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic [lfsf_pkg::BYTE_W-1:0]  shown_byte,
	input  logic                         show,
	input  logic                         fire,
	output lfsf_pkg::lane_res_t          res
);
	import lfsf_pkg::*;

	logic [LEVEL_W-1:0] level_q;
	logic [LEVEL_W-1:0] level_new;

	assign level_new   = level_of(shown_byte);
	assign res.level   = level_new;
	assign res.changed = show && (level_new != level_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q <= '0;
		end else if (fire && show) begin
			level_q <= level_new;
		end
	end

endmodule

### rtl/lfsf_merge.sv
// ----------------------------------------------------------------------------
// lfsf_merge
// Collects the lane results of one frame and sends the changed channels
// one transaction per cycle while m_tready is high, lowest channel first,
// marking the last one.
module lfsf_merge #(
	parameter int CHANNELS = 8
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  lfsf_pkg::lane_res_t            res [CHANNELS],
	input  logic [lfsf_pkg::MODE_W-1:0]    mode,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [lfsf_pkg::M_DATA_W-1:0]  m_tdata, // channel[2:0], level[6:3], mode_now[8:7]
	output logic                           m_tlast
);
	import lfsf_pkg::*;

	localparam int SEL_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

	logic [CHANNELS-1:0] pend_mask_q;
	logic [LEVEL_W-1:0]  pend_lvl_q [CHANNELS];
	logic [MODE_W-1:0]   pend_mode_q;
	logic [CHANNELS-1:0] in_mask;
	logic [CHANNELS-1:0] rest_mask;
	logic [SEL_W-1:0]    sel;
	logic                out_free;
	logic                take;
	logic                m_tvalid_q;
	logic                m_tlast_q;
	logic [CH_W-1:0]     chan_q;
	logic [LEVEL_W-1:0]  lvl_q;
	logic [MODE_W-1:0]   mode_q;

	always_comb begin
		sel = '0;
		for (int i = CHANNELS - 1; i >= 0; i--) begin
			if (pend_mask_q[i]) begin
				sel = SEL_W'(i);
			end
		end
		for (int i = 0; i < CHANNELS; i++) begin
			in_mask[i] = res[i].changed;
		end
	end

	assign rest_mask = pend_mask_q & (pend_mask_q - 1'b1);
	assign out_free  = !m_tvalid_q || m_tready;
	assign take      = out_free && (pend_mask_q != '0);
	assign in_ready  = (pend_mask_q == '0) || (out_free && (rest_mask == '0));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_mask_q <= '0;
			m_tvalid_q  <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				pend_mask_q <= in_mask;
			end else if (take) begin
				pend_mask_q <= rest_mask;
			end
			if (take) begin
				m_tvalid_q <= 1'b1;
			end else if (out_free) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			for (int i = 0; i < CHANNELS; i++) begin
				pend_lvl_q[i] <= res[i].level;
			end
			pend_mode_q <= mode;
		end
		if (take) begin
			chan_q    <= CH_W'(sel);
			lvl_q     <= pend_lvl_q[sel];
			mode_q    <= pend_mode_q;
			m_tlast_q <= (rest_mask == '0);
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tlast  = m_tlast_q;
	assign m_tdata  = {7'b0, mode_q, lvl_q, chan_q};

	a_more_pending: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid_q && !m_tlast_q) |-> (pend_mask_q != '0))
		else $error("non-final result without pending channels");

	a_run_continues: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid_q && m_tready && !m_tlast_q) |=> m_tvalid_q)
		else $error("gap inside a run of results");

	a_take_safe: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> ((pend_mask_q == '0) || ($countones(pend_mask_q) == 1)))
		else $error("new frame accepted over pending results");

endmodule

### rtl/led_frame_source_failover.sv
// ----------------------------------------------------------------------------
// led_frame_source_failover
// LED frame source with static, planned and fast frames and fast-frame
// failover on a millisecond timeout; one result per changed channel level.
// ----------------------------------------------------------------------------
// channel   | direction | payload
// s_axis    | in        | tuser kind, tdata levels/count/forced mode
// m_axis    | out       | tdata channel/level/mode_now, tlast last update
// apb       | in/out    | register 0 fast_timeout_ms at address 0
//
// An input transaction is registered into stage 1 and compared there by
// CHANNELS lanes; its results leave one per cycle while m_tready is high,
// one result for each channel level that the transaction changes.
// One new input is accepted into stage 1 while the previous results drain.
// Reset clears all stores, levels, mode and counter; timeout resets to 5000.
// m_tready low holds the output and backs up into s_tready.
// ----------------------------------------------------------------------------
module led_frame_source_failover #(
	parameter int CHANNELS = 8
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [lfsf_pkg::S_DATA_W-1:0]    s_tdata, // frame_levels[63:0], frame_count[67:64], forced_mode[69:68]
	input  logic [lfsf_pkg::KIND_W-1:0]      s_tuser, // kind[2:0]
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [lfsf_pkg::M_DATA_W-1:0]    m_tdata, // channel[2:0], level[6:3], mode_now[8:7]
	output logic                             m_tlast,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [lfsf_pkg::APB_ADDR_W-1:0]  paddr,
	input  logic [lfsf_pkg::APB_DATA_W-1:0]  pwdata,
	output logic [lfsf_pkg::APB_DATA_W-1:0]  prdata,
	output logic                             pready
);
	import lfsf_pkg::*;

	logic [TMO_W-1:0]   timeout_q;
	logic [BYTE_W-1:0]  static_q  [CHANNELS];
	logic [BYTE_W-1:0]  planned_q [CHANNELS];
	logic [BYTE_W-1:0]  fast_q    [CHANNELS];
	logic               have_static_q;
	logic               have_planned_q;
	logic [MODE_W-1:0]  mode_q;
	logic [SINCE_W-1:0] since_q;

	logic [FRAME_W-1:0] f_levels;
	logic [COUNT_W-1:0] f_count;
	logic [MODE_W-1:0]  f_mode;
	logic [BYTE_W-1:0]  frm      [CHANNELS];
	logic [BYTE_W-1:0]  src      [CHANNELS];
	logic [SINCE_W-1:0] since_inc;
	logic               fallback;
	logic               s_fire;
	logic               show_c;
	logic [MODE_W-1:0]  mode_c;
	logic               wr_static;
	logic               wr_planned;
	logic               wr_fast;
	logic               upd_since;
	logic [SINCE_W-1:0] since_c;

	logic               s1_valid_q;
	logic               show_s1;
	logic [BYTE_W-1:0]  frame_s1 [CHANNELS];
	logic [MODE_W-1:0]  mode_s1;
	logic               s1_ready;
	logic               lane_fire;
	lane_res_t          lane_res [CHANNELS];

	// configuration
	assign pready = 1'b1;
	always_comb begin
		prdata = '0;
		if (paddr[2] == REG_FAST_TIMEOUT) begin
			prdata = {16'b0, timeout_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= TMO_RESET;
		end else if (psel && penable && pwrite && pready
				&& paddr[2] == REG_FAST_TIMEOUT) begin
			timeout_q <= pwdata[TMO_W-1:0];
		end
	end

	// input decode
	assign f_levels = s_tdata[FRAME_W-1:0];
	assign f_count  = s_tdata[FRAME_W +: COUNT_W];
	assign f_mode   = s_tdata[FRAME_W + COUNT_W +: MODE_W];
	assign s_tready = !s1_valid_q || s1_ready;
	assign s_fire   = s_tvalid && s_tready;

	assign since_inc = (since_q == '1) ? since_q : since_q + 1'b1;
	assign fallback  = (mode_q == SRC_FAST) && (since_inc > SINCE_W'(timeout_q));

	always_comb begin
		for (int i = 0; i < CHANNELS; i++) begin
			frm[i] = (COUNT_W'(i) < f_count) ? f_levels[8*i +: 8] : '0;
		end
	end

	always_comb begin
		show_c     = 1'b0;
		mode_c     = mode_q;
		wr_static  = 1'b0;
		wr_planned = 1'b0;
		wr_fast    = 1'b0;
		upd_since  = 1'b0;
		since_c    = since_inc;
		src        = frm;
		case (s_tuser)
			KIND_STATIC: begin
				if (f_count != '0) begin
					wr_static = 1'b1;
					show_c    = 1'b1;
					mode_c    = SRC_STATIC;
				end
			end
			KIND_PLANNED: begin
				if (f_count != '0) begin
					wr_planned = 1'b1;
					show_c     = (mode_q == SRC_PLANNED);
				end
			end
			KIND_FAST: begin
				if (f_count != '0) begin
					wr_fast   = 1'b1;
					show_c    = 1'b1;
					mode_c    = SRC_FAST;
					upd_since = 1'b1;
					since_c   = '0;
				end
			end
			KIND_TICK: begin
				upd_since = 1'b1;
				if (fallback) begin
					show_c = 1'b1;
					if (have_static_q) begin
						mode_c = SRC_STATIC;
						src    = static_q;
					end else if (have_planned_q) begin
						mode_c = SRC_PLANNED;
						src    = planned_q;
					end else begin
						mode_c = SRC_STATIC;
						for (int i = 0; i < CHANNELS; i++) begin
							src[i] = '0;
						end
					end
				end
			end
			KIND_FORCE: begin
				if (f_mode != mode_q && (f_mode == SRC_STATIC
						|| f_mode == SRC_PLANNED || f_mode == SRC_FAST)) begin
					show_c = 1'b1;
					mode_c = f_mode;
					case (f_mode)
						SRC_STATIC:  src = static_q;
						SRC_PLANNED: src = planned_q;
						default:     src = fast_q;
					endcase
				end
			end
			default: begin
				show_c = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CHANNELS; i++) begin
				static_q[i]  <= '0;
				planned_q[i] <= '0;
				fast_q[i]    <= '0;
			end
			have_static_q  <= 1'b0;
			have_planned_q <= 1'b0;
			mode_q         <= SRC_STATIC;
			since_q        <= '0;
		end else if (s_fire) begin
			if (wr_static) begin
				static_q      <= frm;
				have_static_q <= 1'b1;
			end
			if (wr_planned) begin
				planned_q      <= frm;
				have_planned_q <= 1'b1;
			end
			if (wr_fast) begin
				fast_q <= frm;
			end
			if (upd_since) begin
				since_q <= since_c;
			end
			mode_q <= mode_c;
		end
	end

	// stage 1
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (s_tready) begin
			s1_valid_q <= s_fire;
		end
	end

	always_ff @(posedge clk) begin
		if (s_fire) begin
			show_s1  <= show_c;
			frame_s1 <= src;
			mode_s1  <= mode_c;
		end
	end

	assign lane_fire = s1_valid_q && s1_ready;

	for (genvar g = 0; g < CHANNELS; g++) begin : g_lane
		lfsf_lane u_lane (
			.clk        (clk),
			.arst_n     (arst_n),
			.shown_byte (frame_s1[g]),
			.show       (show_s1 && s1_valid_q),
			.fire       (lane_fire),
			.res        (lane_res[g])
		);
	end

	lfsf_merge #(
		.CHANNELS (CHANNELS)
	) u_merge (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s1_valid_q),
		.in_ready (s1_ready),
		.res      (lane_res),
		.mode     (mode_s1),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	a_fast_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(s_fire && s_tuser == KIND_FAST && f_count != '0) |=> (since_q == '0))
		else $error("fast frame did not restart the counter");

	a_static_selects: assert property (@(posedge clk) disable iff (!arst_n)
		(s_fire && s_tuser == KIND_STATIC && f_count != '0) |=> (mode_q == SRC_STATIC))
		else $error("static frame did not select static mode");

	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_valid_q && !s1_ready) |=> (s1_valid_q && $stable(mode_s1)))
		else $error("stage 1 lost a stalled transaction");

endmodule
